// File: src/asgr_pkg.sv
// shared types, constants and helper functions of the sgr attribute parser
`default_nettype none
package asgr_pkg;

  // default depth of the escape buffer, one more than the stored bytes
  localparam int SEQ_BUFFER_DEF = 20;

  // byte codes
  localparam logic [7:0] BYTE_ESC     = 8'h1b;
  localparam logic [7:0] BYTE_BRACKET = 8'h5b;
  localparam logic [7:0] BYTE_SEMI    = 8'h3b;
  localparam logic [7:0] BYTE_M       = 8'h6d;
  localparam logic [7:0] BYTE_ZERO    = 8'h30;
  localparam logic [7:0] BYTE_NINE    = 8'h39;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] PRINT_HI     = 8'h7e;

  // sgr codes
  localparam logic [7:0] SGR_RESET   = 8'd0;
  localparam logic [7:0] SGR_BOLD    = 8'd1;
  localparam logic [7:0] SGR_FAINT   = 8'd2;
  localparam logic [7:0] SGR_ULINE   = 8'd4;
  localparam logic [7:0] SGR_BLINK   = 8'd5;
  localparam logic [7:0] SGR_REV_BL  = 8'd6;
  localparam logic [7:0] SGR_REVERSE = 8'd7;
  localparam logic [7:0] SGR_FG_LO   = 8'd30;
  localparam logic [7:0] SGR_FG_HI   = 8'd37;
  localparam logic [7:0] SGR_BG_LO   = 8'd40;
  localparam logic [7:0] SGR_BG_HI   = 8'd47;

  // configuration register indexes
  localparam logic [1:0] REG_DEFAULT_ATTR = 2'd0;
  localparam logic [1:0] REG_BOLD_EN      = 2'd1;
  localparam logic [1:0] REG_BOLD_ATTR    = 2'd2;

  // reset values of the registers
  localparam logic [7:0] DEFAULT_ATTR_RST = 8'h07;
  localparam logic       BOLD_EN_RST      = 1'b0;
  localparam logic [7:0] BOLD_ATTR_RST    = 8'h0f;

  // ansi colour order (r,g,b) to vga bit order (b,g,r)
  localparam logic [2:0] COLOR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef struct packed {
    logic [7:0] default_attr;
    logic       bold_en;
    logic [7:0] bold_attr;
  } asgr_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FL_RD,
    ST_FL_OUT,
    ST_AP_RD,
    ST_AP_EXEC
  } asgr_state_t;

  // accumulate one decimal digit, saturating at 255
  function automatic logic [7:0] digit_step(input logic [7:0] acc, input logic [3:0] d);
    logic [11:0] t;
    t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, d};
    return (t > 12'd255) ? 8'hff : t[7:0];
  endfunction

  // apply one sgr parameter to the attribute byte
  function automatic logic [7:0] apply_code(input logic [7:0] a, input logic [7:0] code,
                                            input asgr_cfg_t cfg);
    logic [7:0] r;
    logic [2:0] ci;
    r  = a;
    ci = 3'(code - SGR_FG_LO);
    if (code == SGR_RESET) begin
      r = cfg.default_attr;
    end else if (code == SGR_BOLD) begin
      r = cfg.bold_en ? cfg.bold_attr : (a | 8'h08);
    end else if (code == SGR_FAINT) begin
      r = a & 8'hf7;
    end else if (code == SGR_ULINE) begin
      r = a | 8'h01;
    end else if (code == SGR_BLINK) begin
      r = a | 8'h80;
    end else if (code == SGR_REV_BL) begin
      r = (~a) | 8'h80;
    end else if (code == SGR_REVERSE) begin
      r = (~a) & 8'h7f;
    end else if (code inside {[SGR_FG_LO:SGR_FG_HI]}) begin
      r = {a[7:3], COLOR_MAP[ci]};
    end else if (code inside {[SGR_BG_LO:SGR_BG_HI]}) begin
      ci = 3'(code - SGR_BG_LO);
      r = {a[7], COLOR_MAP[ci], a[3:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/asgr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module asgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 19
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/asgr_code_unit.sv
// shared parameter unit: decimal accumulator and sgr attribute update
`default_nettype none
module asgr_code_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire asgr_pkg::asgr_cfg_t  cfg,
  input  wire logic                 step,
  input  wire logic [7:0]           ch,
  output      logic [7:0]           cur_attr
);

  logic [7:0] acc;
  logic [7:0] acc_next;
  logic [7:0] cur_attr_next;
  logic       is_digit;

  // digit grows the parameter, any other byte ends it
  always_comb begin
    is_digit      = (ch inside {[asgr_pkg::BYTE_ZERO:asgr_pkg::BYTE_NINE]});
    acc_next      = acc;
    cur_attr_next = cur_attr;
    if (step) begin
      if (is_digit) begin
        acc_next = asgr_pkg::digit_step(acc, ch[3:0]);
      end else begin
        acc_next      = 8'd0;
        cur_attr_next = asgr_pkg::apply_code(cur_attr, acc, cfg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= 8'd0;
      cur_attr <= asgr_pkg::DEFAULT_ATTR_RST;
    end else begin
      acc      <= acc_next;
      cur_attr <= cur_attr_next;
    end
  end

endmodule
`default_nettype wire

// File: src/ansi_sgr_attribute_parser_core.sv
// top level of the ansi sgr escape parser producing vga text attributes
`default_nettype none
// Terminal bytes enter on s_*, characters with their vga attribute leave on
// m_*. Bytes that are neither printable nor ESC are dropped. A printable byte
// outside a sequence and every byte of a sequence are taken in the idle
// state. A malformed or overlong sequence is flushed from the escape buffer
// with one buffer ram read and one output load per byte, and waits on any
// output stall; a terminating 'm' walks the parameter bytes through the
// shared code unit with one buffer ram read and one code step per byte. A
// flush covers up to SEQ_BUFFER-1 buffered bytes. The input is not ready
// while a flush or walk runs or while a result waits.
module ansi_sgr_attribute_parser_core #(
  parameter int SEQ_BUFFER = asgr_pkg::SEQ_BUFFER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [15:0] m_tdata,   // [7:0] out_char, [15:8] out_attr
  output      logic        m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int BUF_DEPTH = SEQ_BUFFER - 1;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(SEQ_BUFFER);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(BUF_DEPTH);

  asgr_pkg::asgr_state_t state, state_next;
  asgr_pkg::asgr_cfg_t   cfg;

  logic [LEN_W-1:0] seq_len, seq_len_next;
  logic [LEN_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] walk_end, walk_end_next;
  logic [LEN_W-1:0] new_len;
  logic [7:0]       cur_attr;
  logic [7:0]       rdata;

  logic in_fire, keep, is_esc, is_digit, seq_ok, slot_free, walk_last;
  logic ram_we, out_load, step;
  logic [7:0] out_char_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_attr <= asgr_pkg::DEFAULT_ATTR_RST;
      cfg.bold_en      <= asgr_pkg::BOLD_EN_RST;
      cfg.bold_attr    <= asgr_pkg::BOLD_ATTR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        asgr_pkg::REG_DEFAULT_ATTR: cfg.default_attr <= cfg_data;
        asgr_pkg::REG_BOLD_EN:      cfg.bold_en      <= cfg_data[0];
        asgr_pkg::REG_BOLD_ATTR:    cfg.bold_attr    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input byte decode
  always_comb begin
    slot_free = !m_tvalid || m_tready;
    s_tready  = (state == asgr_pkg::ST_IDLE) && slot_free;
    in_fire   = s_tvalid && s_tready;
    is_esc    = (s_tdata == asgr_pkg::BYTE_ESC);
    keep      = is_esc || (s_tdata inside {[asgr_pkg::PRINT_LO:asgr_pkg::PRINT_HI]});
    is_digit  = (s_tdata inside {[asgr_pkg::BYTE_ZERO:asgr_pkg::BYTE_NINE]});
    new_len   = seq_len + LEN_W'(1);
    if (new_len == LEN_W'(2)) begin
      seq_ok = (s_tdata == asgr_pkg::BYTE_BRACKET);
    end else if (new_len == LEN_W'(3)) begin
      seq_ok = is_digit;
    end else begin
      seq_ok = is_digit || (s_tdata == asgr_pkg::BYTE_SEMI) || (s_tdata == asgr_pkg::BYTE_M);
    end
    walk_last = ((idx + LEN_W'(1)) == walk_end);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      asgr_pkg::ST_IDLE: begin
        if (in_fire && keep && (seq_len != '0)) begin
          if (seq_len == LEN_FULL || !seq_ok) begin
            state_next = asgr_pkg::ST_FL_RD;
          end else if (new_len > LEN_W'(3) && s_tdata == asgr_pkg::BYTE_M) begin
            state_next = asgr_pkg::ST_AP_RD;
          end
        end
      end
      asgr_pkg::ST_FL_RD:  state_next = asgr_pkg::ST_FL_OUT;
      asgr_pkg::ST_FL_OUT: begin
        if (slot_free) begin
          state_next = walk_last ? asgr_pkg::ST_IDLE : asgr_pkg::ST_FL_RD;
        end
      end
      asgr_pkg::ST_AP_RD:   state_next = asgr_pkg::ST_AP_EXEC;
      asgr_pkg::ST_AP_EXEC: state_next = walk_last ? asgr_pkg::ST_IDLE : asgr_pkg::ST_AP_RD;
      default: state_next = asgr_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ram_we        = 1'b0;
    out_load      = 1'b0;
    step          = 1'b0;
    out_char_next = s_tdata;
    seq_len_next  = seq_len;
    idx_next      = idx;
    walk_end_next = walk_end;
    case (state)
      asgr_pkg::ST_IDLE: begin
        if (in_fire && keep) begin
          if (seq_len == '0) begin
            if (is_esc) begin
              ram_we       = 1'b1;
              seq_len_next = LEN_W'(1);
            end else begin
              out_load = 1'b1;
            end
          end else if (seq_len == LEN_FULL) begin
            walk_end_next = seq_len;
            idx_next      = '0;
            seq_len_next  = '0;
          end else begin
            ram_we = 1'b1;
            if (!seq_ok) begin
              walk_end_next = new_len;
              idx_next      = '0;
              seq_len_next  = '0;
            end else if (new_len > LEN_W'(3) && s_tdata == asgr_pkg::BYTE_M) begin
              walk_end_next = new_len;
              idx_next      = LEN_W'(2);
              seq_len_next  = '0;
            end else begin
              seq_len_next = new_len;
            end
          end
        end
      end
      asgr_pkg::ST_FL_OUT: begin
        out_char_next = rdata;
        if (slot_free) begin
          out_load = 1'b1;
          idx_next = idx + LEN_W'(1);
        end
      end
      asgr_pkg::ST_AP_EXEC: begin
        step     = 1'b1;
        idx_next = idx + LEN_W'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= asgr_pkg::ST_IDLE;
      seq_len <= '0;
    end else begin
      state   <= state_next;
      seq_len <= seq_len_next;
    end
    idx      <= idx_next;
    walk_end <= walk_end_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {cur_attr, out_char_next};
      m_tlast <= (state == asgr_pkg::ST_IDLE) || walk_last;
    end
  end

  // escape buffer
  asgr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seq_len[ADDR_W-1:0]),
    .wdata (s_tdata),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // shared parameter unit
  asgr_code_unit u_code (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (step),
    .ch       (rdata),
    .cur_attr (cur_attr)
  );

endmodule
`default_nettype wire

// File: src/asgr_checker.sv
// port level checks of the sgr attribute parser and their binding
`default_nettype none
module asgr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input is taken only while the output slot can take a result
  a_in_slot: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("input taken with a stalled result pending");

  // a dropped byte, neither printable nor ESC, makes no result
  a_drop: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid && s_tdata != asgr_pkg::BYTE_ESC &&
    (s_tdata < asgr_pkg::PRINT_LO || s_tdata > asgr_pkg::PRINT_HI) |=> !m_tvalid)
    else $error("dropped byte produced a result");

endmodule

bind ansi_sgr_attribute_parser_core asgr_checker u_asgr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
